// ===== rtl/core/dctd_pkg.sv =====
// Shared types and constants for the dependency-counting task dispatcher.
// No dependencies.
package dctd_pkg;

  localparam int NODES_DEF   = 32;
  localparam int NODE_W      = 5;
  localparam int FUNC_W      = 3;
  localparam int CNT_W       = 6;
  localparam int CNT_MAX     = 63;
  localparam int MAX_RESULTS = 32;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam func_t FUNC_CLEAR  = 3'd0;
  localparam func_t FUNC_MARK   = 3'd1;
  localparam func_t FUNC_EDGE   = 3'd2;
  localparam func_t FUNC_START  = 3'd3;
  localparam func_t FUNC_FINISH = 3'd4;

endpackage

// ===== rtl/core/dctd_store.sv =====
// Single-port-write, single-port-read storage array with per-entry valid bits.
// Entries never written since the last clear read as zero. Uses no package.
module dctd_store #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 6,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr_all,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_v;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else if (rd_en) begin
      rd_v <= valid[rd_addr];
    end
  end

  assign rd_data = rd_v ? rd_q : '0;

endmodule

// ===== rtl/core/dctd_sat_unit.sv =====
// Shared saturating incrementer and comparator for 6-bit counts.
// Depends on dctd_pkg.
module dctd_sat_unit (
  input  logic [dctd_pkg::CNT_W-1:0] a,
  input  logic [dctd_pkg::CNT_W-1:0] b,
  output logic [dctd_pkg::CNT_W-1:0] inc,
  output logic                       at_max,
  output logic                       eq_inc,
  output logic                       eq
);
  import dctd_pkg::*;

  assign at_max = (a == CNT_W'(CNT_MAX));
  assign inc    = at_max ? a : a + 1'b1;
  assign eq_inc = (inc == b);
  assign eq     = (a == b);

endmodule

// ===== rtl/core/dependency_counting_task_dispatcher_top.sv =====
// Dependency-counting task dispatcher: sequencer, graph and counter storage.
// Depends on dctd_pkg, dctd_store, dctd_sat_unit.
//
// Usage: drive func/node/target_node with start; the command is taken on a
// clock edge where start is high and busy is low. Clear, mark and add-edge
// commands produce no results. Start-run and task-finished commands produce
// one or more results, each shown for one cycle with result_strobe high;
// the final one has last set. A command with no ready task gives a single
// result with ready_valid low.
// Sequencing: clear, mark and unknown commands never raise busy; add-edge
// holds busy for the read-modify-write of one successor row. Start-run and a
// finish of a present task scan all NODES entries, one per cycle, through
// the count memories, then strobe the last result in the same cycle as busy
// falls. A finish of an absent task skips the scan. A ready entry is held
// until the next ready entry is found, which strobes it during the scan, or
// until the scan ends.
// Reset clears all graph, counter and run state at once (valid bits).
// The receiver cannot stall; every strobed result is a transfer.
module dependency_counting_task_dispatcher_top #(
  parameter int NODES = dctd_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dctd_pkg::FUNC_W-1:0] func,
  input  logic [dctd_pkg::NODE_W-1:0] node,
  input  logic [dctd_pkg::NODE_W-1:0] target_node,
  output logic                        result_strobe,
  output logic [dctd_pkg::NODE_W-1:0] ready_node,
  output logic                        ready_valid,
  output logic                        run_complete,
  output logic                        last
);
  import dctd_pkg::*;

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EDGE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0]       state;
  func_t            cur_func;
  logic [NODES-1:0] present;
  cnt_t             present_count;
  cnt_t             finished;
  logic             done;
  logic             edge_ok;
  logic [IW-1:0]    edge_src;
  logic [IW-1:0]    edge_tgt;
  logic [IW:0]      rd_idx;
  logic             p_valid;
  logic [IW-1:0]    p_idx;
  logic [IW-1:0]    pend;
  logic             pend_valid;
  cnt_t             emit_cnt;

  logic             accept;
  logic [IW-1:0]    node_idx;
  logic [IW-1:0]    tgt_idx;
  logic             node_in;
  logic             tgt_in;
  logic             a_ok;
  logic             b_ok;
  logic             scan_issue;
  logic             hit;
  logic             emit;

  logic [NODES-1:0] row_rd;
  logic             row_wr;
  cnt_t             pred_rd;
  cnt_t             arr_rd;
  logic             arr_wr;

  cnt_t             u_a;
  cnt_t             u_b;
  cnt_t             u_inc;
  logic             u_at_max;
  logic             u_eq_inc;
  logic             u_eq;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign node_idx   = IW'(node);
  assign tgt_idx    = IW'(target_node);
  assign node_in    = (32'(node) < 32'(NODES));
  assign tgt_in     = (32'(target_node) < 32'(NODES));
  assign a_ok       = node_in && present[node_idx];
  assign b_ok       = tgt_in && present[tgt_idx];
  assign scan_issue = (state == S_SCAN) && (rd_idx != (IW+1)'(NODES));
  assign row_wr     = (state == S_EDGE) && edge_ok && !row_rd[edge_tgt];

  assign hit = p_valid && present[p_idx] &&
               ((cur_func == FUNC_FINISH) ? (row_rd[p_idx] && !u_at_max && u_eq_inc)
                                          : u_eq);
  assign emit   = hit && (emit_cnt != CNT_W'(MAX_RESULTS));
  assign arr_wr = p_valid && (cur_func == FUNC_FINISH) && row_rd[p_idx] && !u_at_max;

  dctd_store #(.DEPTH(NODES), .WIDTH(NODES)) u_rows (
    .clk     (clk),
    .rst     (rst),
    .clr_all (accept && (func == FUNC_CLEAR)),
    .rd_en   (accept && ((func == FUNC_EDGE) || (func == FUNC_FINISH))),
    .rd_addr (node_idx),
    .rd_data (row_rd),
    .wr_en   (row_wr),
    .wr_addr (edge_src),
    .wr_data (row_rd | (NODES'(1) << edge_tgt))
  );

  dctd_store #(.DEPTH(NODES), .WIDTH(CNT_W)) u_pred (
    .clk     (clk),
    .rst     (rst),
    .clr_all (accept && (func == FUNC_CLEAR)),
    .rd_en   ((accept && (func == FUNC_EDGE)) || scan_issue),
    .rd_addr (accept ? tgt_idx : rd_idx[IW-1:0]),
    .rd_data (pred_rd),
    .wr_en   (row_wr),
    .wr_addr (edge_tgt),
    .wr_data (u_inc)
  );

  dctd_store #(.DEPTH(NODES), .WIDTH(CNT_W)) u_arr (
    .clk     (clk),
    .rst     (rst),
    .clr_all (accept && ((func == FUNC_CLEAR) || (func == FUNC_START))),
    .rd_en   (scan_issue),
    .rd_addr (rd_idx[IW-1:0]),
    .rd_data (arr_rd),
    .wr_en   (arr_wr),
    .wr_addr (p_idx),
    .wr_data (u_inc)
  );

  always_comb begin
    u_a = '0;
    u_b = '0;
    unique case (state)
      S_IDLE: begin
        case (func)
          FUNC_MARK: begin
            u_a = present_count;
          end
          FUNC_START: begin
            u_b = present_count;
          end
          FUNC_FINISH: begin
            u_a = finished;
            u_b = present_count;
          end
          default: ;
        endcase
      end
      S_EDGE: begin
        u_a = pred_rd;
      end
      S_SCAN: begin
        if (cur_func == FUNC_FINISH) begin
          u_a = arr_rd;
          u_b = pred_rd;
        end else begin
          u_a = pred_rd;
        end
      end
      default: ;
    endcase
  end

  dctd_sat_unit u_sat (
    .a      (u_a),
    .b      (u_b),
    .inc    (u_inc),
    .at_max (u_at_max),
    .eq_inc (u_eq_inc),
    .eq     (u_eq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      present       <= '0;
      present_count <= '0;
      finished      <= '0;
      p_valid       <= 1'b0;
      pend_valid    <= 1'b0;
      rd_idx        <= '0;
      emit_cnt      <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_func <= func;
            case (func)
              FUNC_CLEAR: begin
                present       <= '0;
                present_count <= '0;
                finished      <= '0;
              end
              FUNC_MARK: begin
                if (node_in && !present[node_idx]) begin
                  present[node_idx] <= 1'b1;
                  present_count     <= u_inc;
                end
              end
              FUNC_EDGE: begin
                edge_ok  <= a_ok && b_ok && (node != target_node);
                edge_src <= node_idx;
                edge_tgt <= tgt_idx;
                state    <= S_EDGE;
              end
              FUNC_START: begin
                finished   <= '0;
                done       <= u_eq;
                rd_idx     <= '0;
                emit_cnt   <= '0;
                pend_valid <= 1'b0;
                state      <= S_SCAN;
              end
              FUNC_FINISH: begin
                rd_idx     <= '0;
                emit_cnt   <= '0;
                pend_valid <= 1'b0;
                if (a_ok) begin
                  finished <= u_inc;
                  done     <= u_eq_inc;
                  state    <= S_SCAN;
                end else begin
                  done  <= u_eq;
                  state <= S_END;
                end
              end
              default: ;
            endcase
          end
        end
        S_EDGE: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_issue) begin
            p_valid <= 1'b1;
            p_idx   <= rd_idx[IW-1:0];
            rd_idx  <= rd_idx + 1'b1;
          end else begin
            p_valid <= 1'b0;
            state   <= S_END;
          end
          if (emit) begin
            if (pend_valid) begin
              result_strobe <= 1'b1;
              ready_node    <= NODE_W'(pend);
              ready_valid   <= 1'b1;
              run_complete  <= done;
              last          <= 1'b0;
            end
            pend       <= p_idx;
            pend_valid <= 1'b1;
            emit_cnt   <= emit_cnt + 1'b1;
          end
        end
        S_END: begin
          result_strobe <= 1'b1;
          ready_node    <= pend_valid ? NODE_W'(pend) : '0;
          ready_valid   <= pend_valid;
          run_complete  <= done;
          last          <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
